### rtl/poc_pkg.sv
// Shared constants, codes and control types for the periodic overlap check unit.
// Depends on nothing; every other file in rtl/ imports it.
package poc_pkg;

  localparam int unsigned DEF_MAX_BEADS  = 1024;
  localparam int unsigned DEF_COORD_BITS = 24;

  localparam int unsigned BOX_W     = 23;  // box length, unsigned Q11.12
  localparam int unsigned ACT_W     = 11;  // active bead count
  localparam int unsigned IDX_W     = 10;  // bead index field
  localparam int unsigned DIAM_W    = 16;  // diameter, unsigned Q4.12
  localparam int unsigned CNT_W     = 10;  // clear count field
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};

  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_QUERY = 1'b1
  } opcode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BOX_X  = 2'd0,
    CFG_BOX_Y  = 2'd1,
    CFG_BOX_Z  = 2'd2,
    CFG_ACTIVE = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic [BOX_W-1:0] x;
    logic [BOX_W-1:0] y;
    logic [BOX_W-1:0] z;
  } box_cfg_t;

  // Controller to datapath
  typedef struct packed {
    logic wr_en;       // write bead store at mem_addr
    logic rd_en;       // read bead store at mem_addr
    logic walk_valid;  // the read entry is a bead to test
    logic load_self;   // capture queried bead, clear the counters
    logic load_out;    // load the result register
    logic zero_out;    // result is 0/0 (write or index beyond store)
  } poc_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic pipe_busy;
  } poc_stat_t;

endpackage

### rtl/poc_datapath.sv
// Bead store, per-bead distance pipeline, clear counters and result register.
// Depends on poc_pkg; driven by poc_ctrl through poc_cmd_t.
module poc_datapath #(
  parameter int unsigned MAX_BEADS  = poc_pkg::DEF_MAX_BEADS,
  parameter int unsigned COORD_BITS = poc_pkg::DEF_COORD_BITS
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  poc_pkg::poc_cmd_t                 cmd,
  output poc_pkg::poc_stat_t                stat,
  input  logic [$clog2(MAX_BEADS)-1:0]      mem_addr,
  input  logic signed [COORD_BITS-1:0]      wr_x,
  input  logic signed [COORD_BITS-1:0]      wr_y,
  input  logic signed [COORD_BITS-1:0]      wr_z,
  input  logic [poc_pkg::DIAM_W-1:0]        wr_diam,
  input  poc_pkg::box_cfg_t                 box,
  output logic                              out_accepted,
  output logic [poc_pkg::CNT_W-1:0]         out_clear_count
);
  import poc_pkg::*;

  localparam int unsigned C      = COORD_BITS;
  localparam int unsigned AD_W   = C + 1;
  localparam int unsigned DW     = (AD_W > BOX_W) ? AD_W : BOX_W;
  localparam int unsigned SQ_W   = 2 * DW;
  localparam int unsigned SUM_W  = SQ_W + 2;
  localparam int unsigned D2_W   = 2 * DIAM_W;
  localparam int unsigned NLANES = 3;

  // Bead store
  logic signed [C-1:0]  mem_x [MAX_BEADS];
  logic signed [C-1:0]  mem_y [MAX_BEADS];
  logic signed [C-1:0]  mem_z [MAX_BEADS];
  logic [DIAM_W-1:0]    mem_d [MAX_BEADS];

  logic [C-1:0]         rd_x_r, rd_y_r, rd_z_r;
  logic [DIAM_W-1:0]    rd_d_r;

  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem_x[mem_addr] <= wr_x;
      mem_y[mem_addr] <= wr_y;
      mem_z[mem_addr] <= wr_z;
      mem_d[mem_addr] <= wr_diam;
    end
    if (cmd.rd_en) begin
      rd_x_r <= mem_x[mem_addr];
      rd_y_r <= mem_y[mem_addr];
      rd_z_r <= mem_z[mem_addr];
      rd_d_r <= mem_d[mem_addr];
    end
  end

  // Lanes, one per axis
  logic [C-1:0]     rd_c   [NLANES];
  logic [C-1:0]     self_r [NLANES];
  logic [BOX_W-1:0] box_l  [NLANES];
  logic [D2_W-1:0]  d2_r;

  assign rd_c[0]  = rd_x_r;
  assign rd_c[1]  = rd_y_r;
  assign rd_c[2]  = rd_z_r;
  assign box_l[0] = box.x;
  assign box_l[1] = box.y;
  assign box_l[2] = box.z;

  always_ff @(posedge clk) begin
    if (cmd.load_self) begin
      for (int l = 0; l < NLANES; l++) begin
        self_r[l] <= rd_c[l];
      end
      d2_r <= D2_W'(rd_d_r) * D2_W'(rd_d_r);
    end
  end

  // Stage 1: absolute difference; stage 2: minimum-image wrap
  logic [AD_W-1:0] diff_c [NLANES];
  logic [AD_W-1:0] ad_c   [NLANES];
  logic [AD_W-1:0] ad_r   [NLANES];
  logic [DW-1:0]   wd_c   [NLANES];
  logic [DW-1:0]   wd_r   [NLANES];
  logic [SQ_W-1:0] sq_r   [NLANES];
  logic [DW-1:0]   d_ext  [NLANES];
  logic [DW-1:0]   l_ext  [NLANES];

  always_comb begin
    for (int l = 0; l < NLANES; l++) begin
      diff_c[l] = {self_r[l][C-1], self_r[l]} - {rd_c[l][C-1], rd_c[l]};
      ad_c[l]   = diff_c[l][AD_W-1] ? (AD_W'(0) - diff_c[l]) : diff_c[l];
      d_ext[l]  = DW'(ad_r[l]);
      l_ext[l]  = DW'(box_l[l]);
      if ({d_ext[l], 1'b0} > {1'b0, l_ext[l]}) begin
        wd_c[l] = (d_ext[l] >= l_ext[l]) ? (d_ext[l] - l_ext[l]) : (l_ext[l] - d_ext[l]);
      end else begin
        wd_c[l] = d_ext[l];
      end
    end
  end

  logic v0_r, v1_r, v2_r, v3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v0_r <= cmd.walk_valid;
      v1_r <= v0_r;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    for (int l = 0; l < NLANES; l++) begin
      ad_r[l] <= ad_c[l];
      wd_r[l] <= wd_c[l];
      sq_r[l] <= SQ_W'(wd_r[l]) * SQ_W'(wd_r[l]);
    end
  end

  // Stage 4: sum of squares against squared diameter
  logic [SUM_W-1:0] r2_c;
  logic             is_clear;
  logic [ACT_W-1:0] clear_r, clear_nxt;
  logic [ACT_W-1:0] walked_r, walked_nxt;

  assign r2_c     = SUM_W'(sq_r[0]) + SUM_W'(sq_r[1]) + SUM_W'(sq_r[2]);
  assign is_clear = (r2_c >= SUM_W'(d2_r));

  always_comb begin
    clear_nxt  = clear_r;
    walked_nxt = walked_r;
    if (cmd.load_self) begin
      clear_nxt  = '0;
      walked_nxt = '0;
    end else if (v3_r) begin
      walked_nxt = walked_r + 1'b1;
      if (is_clear) begin
        clear_nxt = clear_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clear_r  <= '0;
      walked_r <= '0;
    end else begin
      clear_r  <= clear_nxt;
      walked_r <= walked_nxt;
    end
  end

  assign stat.pipe_busy = v0_r | v1_r | v2_r | v3_r;

  // Result register
  logic             acc_r;
  logic [CNT_W-1:0] cnt_r;

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      if (cmd.zero_out) begin
        acc_r <= 1'b0;
        cnt_r <= '0;
      end else begin
        acc_r <= (clear_r == walked_r);
        cnt_r <= (clear_r > ACT_W'(COUNT_MAX)) ? COUNT_MAX : clear_r[CNT_W-1:0];
      end
    end
  end

  assign out_accepted    = acc_r;
  assign out_clear_count = cnt_r;

  a_clear_le_walked: assert property (@(posedge clk) disable iff (!rst_n)
    clear_r <= walked_r)
    else $error("clear count exceeds walked count");

endmodule

### rtl/poc_ctrl.sv
// Controller: input handshake, walk sequencing over the bead store, result valid.
// Depends on poc_pkg; commands poc_datapath.
module poc_ctrl #(
  parameter int unsigned MAX_BEADS = poc_pkg::DEF_MAX_BEADS
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_opcode,
  input  logic [poc_pkg::IDX_W-1:0]     in_bead_index,
  input  logic [poc_pkg::ACT_W-1:0]     active_beads,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [$clog2(MAX_BEADS)-1:0]  mem_addr,
  output poc_pkg::poc_cmd_t             cmd,
  input  poc_pkg::poc_stat_t            stat
);
  import poc_pkg::*;

  localparam int unsigned AW = $clog2(MAX_BEADS);

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD_SELF,
    S_LD_SELF,
    S_WALK,
    S_DRAIN,
    S_FINISH
  } state_t;

  state_t           state_r, state_nxt;
  logic [ACT_W-1:0] k_r, k_nxt;
  logic [ACT_W-1:0] n_r, n_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic             zero_r, zero_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [ACT_W-1:0] n_lim;
  logic             in_range;

  assign n_lim    = (32'(active_beads) > 32'(MAX_BEADS)) ? ACT_W'(MAX_BEADS) : active_beads;
  assign in_range = (32'(in_bead_index) < 32'(MAX_BEADS));

  always_comb begin
    state_nxt     = state_r;
    k_nxt         = k_r;
    n_nxt         = n_r;
    idx_nxt       = idx_r;
    zero_nxt      = zero_r;
    out_valid_nxt = out_valid_r & out_stall;
    cmd           = '0;
    mem_addr      = AW'(k_r);
    case (state_r)
      S_IDLE: begin
        mem_addr = AW'(in_bead_index);
        if (in_valid) begin
          idx_nxt = in_bead_index;
          n_nxt   = n_lim;
          if (!in_range) begin
            zero_nxt  = 1'b1;
            state_nxt = S_FINISH;
          end else if (in_opcode == OP_WRITE) begin
            cmd.wr_en = 1'b1;
            zero_nxt  = 1'b1;
            state_nxt = S_FINISH;
          end else begin
            zero_nxt  = 1'b0;
            state_nxt = S_RD_SELF;
          end
        end
      end
      S_RD_SELF: begin
        mem_addr   = AW'(idx_r);
        cmd.rd_en  = 1'b1;
        state_nxt  = S_LD_SELF;
      end
      S_LD_SELF: begin
        cmd.load_self = 1'b1;
        k_nxt         = '0;
        state_nxt     = (n_r == '0) ? S_FINISH : S_WALK;
      end
      S_WALK: begin
        cmd.rd_en      = 1'b1;
        // skip the queried bead itself
        cmd.walk_valid = (k_r != {1'b0, idx_r});
        if (k_r == n_r - 1'b1) begin
          state_nxt = S_DRAIN;
        end else begin
          k_nxt = k_r + 1'b1;
        end
      end
      S_DRAIN: begin
        if (!stat.pipe_busy) begin
          state_nxt = S_FINISH;
        end
      end
      S_FINISH: begin
        if (!out_valid_r || !out_stall) begin
          cmd.load_out  = 1'b1;
          cmd.zero_out  = zero_r;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      k_r         <= '0;
      n_r         <= '0;
      idx_r       <= '0;
      zero_r      <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      k_r         <= k_nxt;
      n_r         <= n_nxt;
      idx_r       <= idx_nxt;
      zero_r      <= zero_nxt;
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

  a_walk_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_WALK |-> k_r < n_r)
    else $error("walk index beyond active bead count");

  a_finish_drained: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_FINISH |-> !stat.pipe_busy)
    else $error("result taken while pipeline still holds beads");

  a_valid_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_FINISH))
    else $error("result raised outside the finish state");

endmodule

### rtl/periodic_overlap_check_unit.sv
// Periodic overlap check unit: top level, configuration registers and wiring.
// Depends on poc_pkg, poc_ctrl and poc_datapath.
// Usage:
//   Input channel (in_valid / in_stall): a transfer with in_opcode = write stores
//   position and diameter of bead in_bead_index; with in_opcode = query it tests
//   that bead against every other active bead under the periodic box.
//   Result channel (out_valid / out_stall): one transfer per input item, carrying
//   out_accepted and out_clear_count (both zero for a write or an index beyond
//   the store).
//   Configuration (cfg_we / cfg_index / cfg_wdata): box lengths and the active
//   bead count; write them only while no item is in flight.
// Operation: a write goes to the finish state, which loads the result register;
//   the unit is idle for the next item as the result appears. A query over n
//   active beads first reads and captures the queried bead, then walks the store
//   one bead per cycle through a single read port and a four-stage distance
//   pipeline, drains the pipeline and loads the result; input stalls meanwhile.
// Reset (rst_n, synchronous): zeroes control, configuration and counters; the
//   bead store keeps its contents and must be written before it is queried.
// A stalled result is held in the output register; the unit still accepts one
//   further item and works on it, then waits for the result register to drain.
module periodic_overlap_check_unit #(
  parameter int unsigned MAX_BEADS  = poc_pkg::DEF_MAX_BEADS,
  parameter int unsigned COORD_BITS = poc_pkg::DEF_COORD_BITS
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           in_opcode,
  input  logic [poc_pkg::IDX_W-1:0]      in_bead_index,
  input  logic signed [COORD_BITS-1:0]   in_pos_x,
  input  logic signed [COORD_BITS-1:0]   in_pos_y,
  input  logic signed [COORD_BITS-1:0]   in_pos_z,
  input  logic [poc_pkg::DIAM_W-1:0]     in_bead_diameter,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic                           out_accepted,
  output logic [poc_pkg::CNT_W-1:0]      out_clear_count,
  input  logic                           cfg_we,
  input  logic [poc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [poc_pkg::BOX_W-1:0]      cfg_wdata
);
  import poc_pkg::*;

  localparam int unsigned AW = $clog2(MAX_BEADS);

  box_cfg_t         box_r;
  logic [ACT_W-1:0] active_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      box_r    <= '0;
      active_r <= '0;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        CFG_BOX_X:  box_r.x  <= cfg_wdata;
        CFG_BOX_Y:  box_r.y  <= cfg_wdata;
        CFG_BOX_Z:  box_r.z  <= cfg_wdata;
        CFG_ACTIVE: active_r <= cfg_wdata[ACT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  poc_cmd_t        cmd;
  poc_stat_t       stat;
  logic [AW-1:0]   mem_addr;

  poc_ctrl #(
    .MAX_BEADS (MAX_BEADS)
  ) u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_opcode     (in_opcode),
    .in_bead_index (in_bead_index),
    .active_beads  (active_r),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .mem_addr      (mem_addr),
    .cmd           (cmd),
    .stat          (stat)
  );

  poc_datapath #(
    .MAX_BEADS  (MAX_BEADS),
    .COORD_BITS (COORD_BITS)
  ) u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .stat            (stat),
    .mem_addr        (mem_addr),
    .wr_x            (in_pos_x),
    .wr_y            (in_pos_y),
    .wr_z            (in_pos_z),
    .wr_diam         (in_bead_diameter),
    .box             (box_r),
    .out_accepted    (out_accepted),
    .out_clear_count (out_clear_count)
  );

endmodule
